/* rtl/ccal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_pkg: shared types and constants of the calendar clock
// Time/date record, load record, alarm record, limits and month lengths.
// ----------------------------------------------------------------------------
package ccal_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_MINUTE = 2'd0,
    CFG_ALARM_HOUR   = 2'd1,
    CFG_ALARM_PM     = 2'd2,
    CFG_UNUSED       = 2'd3
  } ccal_cfg_idx_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [3:0] hour;
    logic       pm;
    logic [4:0] day;
    logic [3:0] month;
  } ccal_time_t;

  typedef struct packed {
    logic       mode;
    logic [5:0] sec;
    logic [5:0] min;
    logic [3:0] hour;
    logic       pm;
    logic [4:0] day;
    logic [3:0] month;
  } ccal_load_t;

  typedef struct packed {
    logic [5:0] min;
    logic [3:0] hour;
    logic       pm;
  } ccal_alarm_t;

  localparam logic       MODE_TICK = 1'b0;
  localparam logic       MODE_LOAD = 1'b1;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [3:0] HOUR_MAX  = 4'd11;
  localparam logic [4:0] DAY_MIN   = 5'd1;
  localparam logic [3:0] MONTH_MIN = 4'd1;
  localparam logic [3:0] MONTH_MAX = 4'd12;

  localparam ccal_time_t TIME_RESET = '{
    sec:   6'd52,
    min:   6'd4,
    hour:  4'd4,
    pm:    1'b1,
    day:   5'd22,
    month: 4'd8
  };

  localparam ccal_alarm_t ALARM_RESET = '{min: 6'd0, hour: 4'd0, pm: 1'b0};

  // Days in a month, no leap year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

/* rtl/ccal_next.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_next: next time/date and alarm compare
// Applies one beat (tick or load) to the current time and compares the
// result against the alarm registers.
// ----------------------------------------------------------------------------
module ccal_next (
  input  ccal_pkg::ccal_time_t  cur,
  input  ccal_pkg::ccal_load_t  ld,
  input  ccal_pkg::ccal_alarm_t alarm,
  output ccal_pkg::ccal_time_t  nxt,
  output logic                  alarm_hit
);
  import ccal_pkg::*;

  ccal_time_t tick_t;
  ccal_time_t load_t;
  logic [5:0] day_inc;

  // Tick: cascade of compare-and-increment.
  always_comb begin
    tick_t  = cur;
    day_inc = {1'b0, cur.day} + 6'd1;
    if (cur.sec >= SEC_MAX) begin
      tick_t.sec = 6'd0;
      if (cur.min >= MIN_MAX) begin
        tick_t.min = 6'd0;
        if (cur.hour >= HOUR_MAX) begin
          tick_t.hour = 4'd0;
          tick_t.pm   = ~cur.pm;
          if (cur.pm) begin
            // PM to AM: advance the day, roll the month past its length
            if (day_inc > {1'b0, month_len(cur.month)}) begin
              tick_t.day   = DAY_MIN;
              tick_t.month = (cur.month >= MONTH_MAX) ? MONTH_MIN : cur.month + 4'd1;
            end else begin
              tick_t.day = day_inc[4:0];
            end
          end
        end else begin
          tick_t.hour = cur.hour + 4'd1;
        end
      end else begin
        tick_t.min = cur.min + 6'd1;
      end
    end else begin
      tick_t.sec = cur.sec + 6'd1;
    end
  end

  // Load: clamp each field into range; a zero day becomes one, but a day past the month's end is kept.
  always_comb begin
    load_t.sec  = (ld.sec > SEC_MAX)   ? SEC_MAX  : ld.sec;
    load_t.min  = (ld.min > MIN_MAX)   ? MIN_MAX  : ld.min;
    load_t.hour = (ld.hour > HOUR_MAX) ? HOUR_MAX : ld.hour;
    load_t.pm   = ld.pm;
    load_t.day  = (ld.day == 5'd0)     ? DAY_MIN  : ld.day;
    if (ld.month == 4'd0) begin
      load_t.month = MONTH_MIN;
    end else if (ld.month > MONTH_MAX) begin
      load_t.month = MONTH_MAX;
    end else begin
      load_t.month = ld.month;
    end
  end

  assign nxt       = (ld.mode == MODE_LOAD) ? load_t : tick_t;
  assign alarm_hit = (nxt.min == alarm.min) && (nxt.hour == alarm.hour) &&
                     (nxt.pm == alarm.pm);

endmodule

/* rtl/calendar_clock_with_alarm_top.sv */
`timescale 1ns / 1ps
// Path: a beat is taken into the input register and passes the next-time logic into the result register at out_*.
// Throughput: one beat per cycle, sustained, while out_ready stays high.
// Reset (rst_n low, synchronous): time returns to 4:04:52 PM, 22 August,
// alarm registers clear to 12:00 AM (hour 0, minute 0), both stages empty.
// ----------------------------------------------------------------------------
// calendar_clock_with_alarm_top: 12-hour clock/calendar with alarm compare
// Input register, single-pass next-time logic and a result register.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [ccal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccal_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [5:0]                     in_load_seconds,
  input  logic [5:0]                     in_load_minutes,
  input  logic [3:0]                     in_load_hours,
  input  logic                           in_load_pm,
  input  logic [4:0]                     in_load_day,
  input  logic [3:0]                     in_load_month,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [5:0]                     out_seconds_now,
  output logic [5:0]                     out_minutes_now,
  output logic [3:0]                     out_hours_now,
  output logic                           out_pm_now,
  output logic [4:0]                     out_day_now,
  output logic [3:0]                     out_month_now,
  output logic                           out_alarm_hit
);
  import ccal_pkg::*;

  // Alarm registers
  ccal_alarm_t alarm_r;

  // Input stage: holds one accepted beat
  logic       s1_valid_r;
  ccal_load_t s1_load_r;

  // Running time and date
  ccal_time_t time_r;
  ccal_time_t time_nxt;
  logic       alarm_hit_nxt;

  // Result stage
  logic       out_valid_r;
  ccal_time_t out_time_r;
  logic       out_alarm_r;

  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  // The result register frees up when empty or when its beat is taken this
  // cycle; the input stage advances into it whenever it frees up.
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= ALARM_RESET;
    end else if (cfg_wr_en) begin
      case (ccal_cfg_idx_t'(cfg_index))
        CFG_ALARM_MINUTE: alarm_r.min  <= cfg_wdata[5:0];
        CFG_ALARM_HOUR:   alarm_r.hour <= cfg_wdata[3:0];
        CFG_ALARM_PM:     alarm_r.pm   <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input stage payload: capture on every accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_load_r <= '{mode:  in_mode,
                     sec:   in_load_seconds,
                     min:   in_load_minutes,
                     hour:  in_load_hours,
                     pm:    in_load_pm,
                     day:   in_load_day,
                     month: in_load_month};
    end
  end

  // Next time for the beat in the input stage, plus the alarm compare
  ccal_next u_next (
    .cur       (time_r),
    .ld        (s1_load_r),
    .alarm     (alarm_r),
    .nxt       (time_nxt),
    .alarm_hit (alarm_hit_nxt)
  );

  // Time advances exactly once per beat, as the beat leaves the input stage,
  // so the following beat sees the updated time in the very next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= TIME_RESET;
    end else if (s1_fire) begin
      time_r <= time_nxt;
    end
  end

  // Result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_time_r  <= time_nxt;
      out_alarm_r <= alarm_hit_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seconds_now = out_time_r.sec;
  assign out_minutes_now = out_time_r.min;
  assign out_hours_now   = out_time_r.hour;
  assign out_pm_now      = out_time_r.pm;
  assign out_day_now     = out_time_r.day;
  assign out_month_now   = out_time_r.month;
  assign out_alarm_hit   = out_alarm_r;

  // Time fields never leave their ranges
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.sec <= SEC_MAX) && (time_r.min <= MIN_MAX) && (time_r.hour <= HOUR_MAX) &&
    (time_r.month >= MONTH_MIN) && (time_r.month <= MONTH_MAX) && (time_r.day != 5'd0))
    else $error("time/date register out of range");

  // A beat leaving the input stage lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("beat lost between input and result stage");

  // A tick that does not wrap the seconds adds exactly one second
  a_tick_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_load_r.mode == MODE_TICK) && (time_r.sec != SEC_MAX))
    |=> (time_r.sec == $past(time_r.sec) + 6'd1))
    else $error("seconds did not advance on tick");

  // Time holds while no beat moves
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(time_r))
    else $error("time changed without a beat");

  // An empty input stage always accepts
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while empty");

endmodule

/* bench/calendar_clock_with_alarm_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_with_alarm_top_test: self-checking bench for the calendar clock
// Drives tick and load beats through the valid/ready input channel, programs
// the alarm registers between phases, and checks every result beat against a
// cycle-free model of the 12-hour clock, the calendar and the alarm compare.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm_top_test;
  import ccal_pkg::*;

  // Hold-off after the last result: each beat passes the input and the result
  // register, so the hold-off lets any stray result beat show up and be checked.
  localparam int DRAIN_CYCLES = 8;
  // Slowest correct run is about 625 beats, each with the longest idle gap and output stall.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BEATS  = 100;
  localparam int PHASE_COUNT  = 6;

  // --------------------------------------------------------------------------
  // Clock/calendar model plus the store of expected result beats.
  // --------------------------------------------------------------------------
  class calendar_scoreboard;
    ccal_time_t  clock_now;
    ccal_alarm_t alarm_set;
    ccal_time_t  expected_time[$];
    logic        expected_hit[$];
    int          fails;

    function new();
      clock_now = '{sec: 6'd52, min: 6'd4, hour: 4'd4, pm: 1'b1, day: 5'd22, month: 4'd8};
      alarm_set = '{min: 6'd0, hour: 4'd0, pm: 1'b0};
      fails     = 0;
    endfunction

    function int outstanding();
      return expected_time.size();
    endfunction

    // Keep only the bits each register holds; the spare index writes nothing.
    function void write_reg(ccal_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ALARM_MINUTE: alarm_set.min  = val[5:0];
        CFG_ALARM_HOUR:   alarm_set.hour = val[3:0];
        CFG_ALARM_PM:     alarm_set.pm   = val[0];
        default: ;
      endcase
    endfunction

    function int days_in_month(logic [3:0] m);
      case (m)
        4'd2:                     return 28;
        4'd4, 4'd6, 4'd9, 4'd11:  return 30;
        default:                  return 31;
      endcase
    endfunction

    // A loaded day past the month's end rolls here too.
    function void advance_day();
      int d;
      d = clock_now.day + 1;
      if (d > days_in_month(clock_now.month)) begin
        d = 1;
        clock_now.month = (clock_now.month >= MONTH_MAX) ? MONTH_MIN
                                                         : clock_now.month + 4'd1;
      end
      clock_now.day = d[4:0];
    endfunction

    function void tick_once();
      if (clock_now.sec < SEC_MAX) begin
        clock_now.sec = clock_now.sec + 6'd1;
        return;
      end
      clock_now.sec = 6'd0;
      if (clock_now.min < MIN_MAX) begin
        clock_now.min = clock_now.min + 6'd1;
        return;
      end
      clock_now.min = 6'd0;
      if (clock_now.hour < HOUR_MAX) begin
        clock_now.hour = clock_now.hour + 4'd1;
        return;
      end
      clock_now.hour = 4'd0;
      if (!clock_now.pm) begin
        clock_now.pm = 1'b1;
      end else begin
        clock_now.pm = 1'b0;
        advance_day();
      end
    endfunction

    // Apply one accepted input beat and queue the result it must produce.
    function void note_beat(ccal_load_t b);
      if (b.mode == MODE_LOAD) begin
        clock_now.sec   = (b.sec  > SEC_MAX)  ? SEC_MAX  : b.sec;
        clock_now.min   = (b.min  > MIN_MAX)  ? MIN_MAX  : b.min;
        clock_now.hour  = (b.hour > HOUR_MAX) ? HOUR_MAX : b.hour;
        clock_now.pm    = b.pm;
        clock_now.day   = (b.day < DAY_MIN) ? DAY_MIN : b.day;
        clock_now.month = (b.month < MONTH_MIN) ? MONTH_MIN :
                          (b.month > MONTH_MAX) ? MONTH_MAX : b.month;
      end else begin
        tick_once();
      end
      expected_time.push_back(clock_now);
      expected_hit.push_back(clock_now.min == alarm_set.min &&
                             clock_now.hour == alarm_set.hour &&
                             clock_now.pm == alarm_set.pm);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(ccal_time_t got, logic got_hit);
      ccal_time_t want;
      logic       want_hit;
      if (expected_time.size() == 0) begin
        $error("result beat with no expectation waiting");
        fails++;
        return;
      end
      want     = expected_time.pop_front();
      want_hit = expected_hit.pop_front();
      compare_field("seconds_now", want.sec,   got.sec);
      compare_field("minutes_now", want.min,   got.min);
      compare_field("hours_now",   want.hour,  got.hour);
      compare_field("pm_now",      want.pm,    got.pm);
      compare_field("day_now",     want.day,   got.day);
      compare_field("month_now",   want.month, got.month);
      compare_field("alarm_hit",   want_hit,   got_hit);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  ccal_cfg_idx_t         cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [5:0]            in_load_seconds;
  logic [5:0]            in_load_minutes;
  logic [3:0]            in_load_hours;
  logic                  in_load_pm;
  logic [4:0]            in_load_day;
  logic [3:0]            in_load_month;
  logic                  out_valid;
  logic                  out_ready;
  logic [5:0]            out_seconds_now;
  logic [5:0]            out_minutes_now;
  logic [3:0]            out_hours_now;
  logic                  out_pm_now;
  logic [4:0]            out_day_now;
  logic [3:0]            out_month_now;
  logic                  out_alarm_hit;

  calendar_scoreboard sb;
  int                 cycle_count = 0;
  bit                 calm_in     = 1'b0;
  bit                 calm_out    = 1'b0;

  calendar_clock_with_alarm_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_load_seconds (in_load_seconds),
    .in_load_minutes (in_load_minutes),
    .in_load_hours   (in_load_hours),
    .in_load_pm      (in_load_pm),
    .in_load_day     (in_load_day),
    .in_load_month   (in_load_month),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seconds_now (out_seconds_now),
    .out_minutes_now (out_minutes_now),
    .out_hours_now   (out_hours_now),
    .out_pm_now      (out_pm_now),
    .out_day_now     (out_day_now),
    .out_month_now   (out_month_now),
    .out_alarm_hit   (out_alarm_hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Beat builders
  // --------------------------------------------------------------------------
  // Fill every load field with random bits, so out-of-range codes show up too.
  function automatic ccal_load_t random_load_beat();
    ccal_load_t b;
    b.mode  = MODE_LOAD;
    b.sec   = 6'($urandom);
    b.min   = 6'($urandom);
    b.hour  = 4'($urandom);
    b.pm    = 1'($urandom);
    b.day   = 5'($urandom);
    b.month = 4'($urandom);
    return b;
  endfunction

  // Ticks carry random junk in the load fields; the block must ignore it.
  function automatic ccal_load_t tick_beat();
    ccal_load_t b;
    b      = random_load_beat();
    b.mode = MODE_TICK;
    return b;
  endfunction

  function automatic ccal_load_t load_beat(int s, int m, int h, int p, int d, int mo);
    ccal_load_t b;
    b.mode  = MODE_LOAD;
    b.sec   = 6'(s);
    b.min   = 6'(m);
    b.hour  = 4'(h);
    b.pm    = 1'(p);
    b.day   = 5'(d);
    b.month = 4'(mo);
    return b;
  endfunction

  // Land a few seconds short of a carry so the ticks that follow ripple
  // through minutes, hours, half-day, day and month, or across the alarm.
  function automatic ccal_load_t near_rollover_beat();
    ccal_load_t b;
    b     = random_load_beat();
    b.sec = 6'($urandom_range(55, 63));
    case ($urandom_range(0, 2))
      0: begin
        b.min  = 6'($urandom_range(58, 63));
        b.hour = 4'($urandom_range(10, 15));
        b.day  = 5'($urandom_range(27, 31));
      end
      1: begin
        b.min  = sb.alarm_set.min - 6'($urandom_range(0, 1));
        b.hour = sb.alarm_set.hour;
        b.pm   = sb.alarm_set.pm;
      end
      default: begin
        b.day = 5'($urandom_range(27, 31));
      end
    endcase
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one input beat and return at the edge that takes it. Leave valid
  // high so a back-to-back beat needs no second assignment in the same step.
  task automatic send_beat(ccal_load_t b);
    int gap;
    if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= b.mode;
    in_load_seconds <= b.sec;
    in_load_minutes <= b.min;
    in_load_hours   <= b.hour;
    in_load_pm      <= b.pm;
    in_load_day     <= b.day;
    in_load_month   <= b.month;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
  endtask

  task automatic write_reg(ccal_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Program all alarm registers, then poke the spare index, which must do nothing.
  task automatic program_alarm(logic [5:0] m, logic [5:0] h, logic [5:0] p);
    write_reg(CFG_ALARM_MINUTE, m);
    write_reg(CFG_ALARM_HOUR, h);
    write_reg(CFG_ALARM_PM, p);
    write_reg(CFG_UNUSED, 6'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Stop offering beats, wait for every expected result, then hold off.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed "load near a carry, then tick" runs; the rest is
  // single random loads and bare ticks.
  task automatic run_random(int count);
    int sent;
    int run;
    int k;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_beat(near_rollover_beat());
          sent++;
          run = $urandom_range(1, 6);
          for (k = 0; k < run; k++) begin
            send_beat(tick_beat());
            sent++;
          end
        end
        6, 7: begin
          send_beat(random_load_beat());
          sent++;
        end
        default: begin
          run = $urandom_range(1, 4);
          for (k = 0; k < run; k++) begin
            send_beat(tick_beat());
            sent++;
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, then check each beat taken.
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    int         stall;
    ccal_time_t got;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{sec: out_seconds_now, min: out_minutes_now, hour: out_hours_now,
              pm: out_pm_now, day: out_day_now, month: out_month_now};
      sb.check_result(got, out_alarm_hit);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    sb = new();
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_ALARM_MINUTE;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_TICK;
    in_load_seconds <= '0;
    in_load_minutes <= '0;
    in_load_hours   <= '0;
    in_load_pm      <= 1'b0;
    in_load_day     <= '0;
    in_load_month   <= '0;
    out_ready       <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Alarm at 12:00 AM, same as after reset.
    program_alarm(6'd0, 6'd0, 6'd0);

    // Directed: first tick from the reset time.
    send_beat(tick_beat());
    // Every load field above range clamps; day and month zero clamp to one.
    send_beat(load_beat(63, 63, 15, 1, 0, 0));
    send_beat(tick_beat());                          // PM wrap into next day
    send_beat(load_beat(59, 59, 11, 0, 31, 15));     // month clamps to 12
    send_beat(tick_beat());                          // AM becomes PM
    send_beat(load_beat(59, 59, 11, 1, 31, 12));
    send_beat(tick_beat());                          // year wrap to Jan 1
    send_beat(load_beat(59, 59, 11, 1, 31, 2));      // day past Feb's end kept
    send_beat(tick_beat());                          // rolls to Mar 1
    send_beat(load_beat(59, 59, 11, 1, 28, 2));
    send_beat(tick_beat());                          // Feb 28 -> Mar 1
    send_beat(load_beat(59, 59, 11, 1, 30, 4));
    send_beat(tick_beat());                          // 30-day month end
    send_beat(load_beat(59, 59, 11, 1, 29, 4));
    send_beat(tick_beat());                          // Apr 29 -> Apr 30
    send_beat(load_beat(0, 0, 0, 0, 1, 1));          // low extremes; alarm match on load
    send_beat(load_beat(58, 59, 11, 1, 31, 7));
    send_beat(tick_beat());
    send_beat(tick_beat());                          // Jul 31 -> Aug 1
    send_beat(load_beat(59, 0, 0, 0, 15, 6));
    send_beat(tick_beat());                          // minute carry only
    send_beat(load_beat(59, 59, 3, 0, 15, 6));
    send_beat(tick_beat());                          // hour carry only
    send_beat(load_beat(40, 60, 12, 0, 16, 13));     // minute, hour and month just past their limits
    send_beat(load_beat(61, 30, 5, 1, 31, 14));
    wait_drained();

    // Random phases, each with its own alarm setting. Hour and half-day
    // writes carry junk in the upper data bits, which the registers drop.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: program_alarm(6'd59, 6'd11, 6'd1);
        1: program_alarm(6'd0, {2'b11, 4'd0}, 6'b111110);
        2: program_alarm(6'd63, 6'h3F, 6'h3F);       // out of range: never matches
        4: program_alarm(6'd60, 6'd12, 6'd0);        // just past range: never matches
        default: program_alarm(6'($urandom_range(0, 59)),
                               {2'($urandom), 4'($urandom_range(0, 11))},
                               {5'($urandom), 1'($urandom)});
      endcase
      run_random(PHASE_BEATS);
      wait_drained();
    end

    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
